// ----- hdl/aap_pkg.sv -----
`timescale 1ns / 1ps

package aap_pkg;

    localparam int COORD_W = 32;
    localparam int ENTRY_W = 18;
    localparam int QW      = 34;

    typedef logic signed [QW-1:0]      q_t;
    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // Matrix and status handed from the coefficient builder to the datapath.
    typedef struct packed {
        logic                    busy;
        logic                    zero_axis;
        logic [8:0][ENTRY_W-1:0] entry;
    } coef_t;

    localparam q_t              Q_ONE        = 34'sd268435456;
    localparam logic [QW-1:0]   HALF_PI      = 34'd421657428;
    localparam logic [QW-1:0]   HALF_PI_HALF = 34'd210828714;
    // Eight and a half quarter turns keep the reduction operand positive.
    localparam logic [QW:0]     RED_BIAS     = 35'd3584088138;
    localparam entry_t          ENTRY_ONE    = 18'sd65536;

    localparam logic [1:0] REG_ANGLE  = 2'd0;
    localparam logic [1:0] REG_AXIS_X = 2'd1;
    localparam logic [1:0] REG_AXIS_Y = 2'd2;
    localparam logic [1:0] REG_AXIS_Z = 2'd3;

endpackage

// ----- hdl/aap_if.sv -----
`timescale 1ns / 1ps

interface aap_point_if;
    logic            valid;
    logic            ready;
    aap_pkg::coord_t point_x;
    aap_pkg::coord_t point_y;
    aap_pkg::coord_t point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface aap_result_if;
    logic            valid;
    logic            ready;
    aap_pkg::coord_t rotated_x;
    aap_pkg::coord_t rotated_y;
    aap_pkg::coord_t rotated_z;
    logic            zero_axis;

    modport source (output valid, rotated_x, rotated_y, rotated_z, zero_axis, input ready);
    modport sink   (input valid, rotated_x, rotated_y, rotated_z, zero_axis, output ready);
endinterface

// ----- hdl/aap_div.sv -----
`timescale 1ns / 1ps

module aap_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [59:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [59:0] quo
);
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [59:0] quo_reg;
    logic [32:0] rs;
    logic        ge;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        rs = {rem_reg, quo_reg[59]};
        ge = (rs >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'd59;
            end
            else if (run_reg)
            begin
                if (cnt_reg == 6'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? 32'(rs - {1'b0, den_reg}) : rs[31:0];
            quo_reg <= {quo_reg[58:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- hdl/aap_mat.sv -----
`timescale 1ns / 1ps

module aap_mat (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output aap_pkg::coef_t coef
);
    import aap_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_START = 5'd1;
    localparam logic [4:0] ST_RED   = 5'd2;
    localparam logic [4:0] ST_R2    = 5'd3;
    localparam logic [4:0] ST_R2W   = 5'd4;
    localparam logic [4:0] ST_TM    = 5'd5;
    localparam logic [4:0] ST_TD    = 5'd6;
    localparam logic [4:0] ST_TW    = 5'd7;
    localparam logic [4:0] ST_SIN   = 5'd8;
    localparam logic [4:0] ST_SINW  = 5'd9;
    localparam logic [4:0] ST_QUAD  = 5'd10;
    localparam logic [4:0] ST_SUM   = 5'd11;
    localparam logic [4:0] ST_SQRT  = 5'd12;
    localparam logic [4:0] ST_NDIV  = 5'd13;
    localparam logic [4:0] ST_NW    = 5'd14;
    localparam logic [4:0] ST_EA    = 5'd15;
    localparam logic [4:0] ST_EB    = 5'd16;
    localparam logic [4:0] ST_EC    = 5'd17;
    localparam logic [4:0] ST_ED    = 5'd18;

    localparam logic [3:0] DI_SIN_LAST = 4'd4;
    localparam logic [3:0] DI_COS_LAST = 4'd10;
    localparam logic [3:0] EI_LAST     = 4'd8;

    typedef struct packed {
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] k;
        logic       sub;
        logic       diag;
    } ent_t;

    function automatic logic [31:0] mag32(q_t v);
        logic [QW-1:0] m;
        m = v[QW-1] ? -v : v;
        return m[31:0];
    endfunction

    // Q.28 product, rounded half away from zero.
    function automatic q_t mulq(q_t a, q_t b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] p;
        q_t          m;
        ma = mag32(a);
        mb = mag32(b);
        p  = ma * mb + 64'd134217728;
        m  = q_t'({1'b0, p[QW+26:28]});
        return (a[QW-1] ^ b[QW-1]) ? -m : m;
    endfunction

    function automatic entry_t to_entry(q_t v);
        logic [QW-1:0]      mg;
        logic [QW-1:0]      rm;
        logic signed [QW:0] sv;
        mg = v[QW-1] ? -v : v;
        rm = (mg + 34'd2048) >> 12;
        sv = v[QW-1] ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
        if (sv > 35'sd131071)
            return 18'sh1FFFF;
        else if (sv < -35'sd131072)
            return 18'sh20000;
        else
            return entry_t'(sv);
    endfunction

    // The series divisors are small constants, so each division is a multiply
    // by a rounded-up reciprocal and a shift. The series terms stay below 2^28,
    // where the quotient matches a truncating division.
    function automatic logic [28:0] recip_mul(logic [3:0] d);
        case (d)
            4'd0:    return 29'd312361258;
            4'd1:    return 29'd477218589;
            4'd2:    return 29'd409044505;
            4'd3:    return 29'd429496730;
            4'd4:    return 29'd357913942;
            4'd5:    return 29'd520602097;
            4'd6:    return 29'd381774871;
            4'd7:    return 29'd306783379;
            4'd8:    return 29'd286331154;
            4'd9:    return 29'd357913942;
            default: return 29'd268435456;
        endcase
    endfunction

    function automatic logic [5:0] recip_shift(logic [3:0] d);
        case (d)
            4'd0:    return 6'd35;
            4'd1:    return 6'd35;
            4'd2:    return 6'd34;
            4'd3:    return 6'd33;
            4'd4:    return 6'd31;
            4'd5:    return 6'd36;
            4'd6:    return 6'd35;
            4'd7:    return 6'd34;
            4'd8:    return 6'd33;
            4'd9:    return 6'd32;
            default: return 6'd29;
        endcase
    endfunction

    // Row, column, sine term axis and sign of each matrix entry.
    function automatic ent_t ent_info(logic [3:0] e);
        case (e)
            4'd0:    return '{i: 2'd0, j: 2'd0, k: 2'd0, sub: 1'b0, diag: 1'b1};
            4'd1:    return '{i: 2'd0, j: 2'd1, k: 2'd2, sub: 1'b1, diag: 1'b0};
            4'd2:    return '{i: 2'd0, j: 2'd2, k: 2'd1, sub: 1'b0, diag: 1'b0};
            4'd3:    return '{i: 2'd1, j: 2'd0, k: 2'd2, sub: 1'b0, diag: 1'b0};
            4'd4:    return '{i: 2'd1, j: 2'd1, k: 2'd0, sub: 1'b0, diag: 1'b1};
            4'd5:    return '{i: 2'd1, j: 2'd2, k: 2'd0, sub: 1'b1, diag: 1'b0};
            4'd6:    return '{i: 2'd2, j: 2'd0, k: 2'd1, sub: 1'b1, diag: 1'b0};
            4'd7:    return '{i: 2'd2, j: 2'd1, k: 2'd0, sub: 1'b0, diag: 1'b0};
            default: return '{i: 2'd2, j: 2'd2, k: 2'd0, sub: 1'b0, diag: 1'b1};
        endcase
    endfunction

    logic [4:0]          state_reg;
    logic [4:0]          state_next;
    logic [15:0]         angle_reg;
    logic [15:0]         ax_reg;
    logic [15:0]         ay_reg;
    logic [15:0]         az_reg;
    entry_t              entry_reg [9];
    logic                zero_reg;

    logic [QW-1:0]       q_reg;
    logic [1:0]          kq_reg;
    q_t                  r_reg;
    q_t                  r2_reg;
    q_t                  u_reg;
    q_t                  s_reg;
    q_t                  c_reg;
    q_t                  sn_reg;
    q_t                  cs_reg;
    q_t                  t_reg;
    q_t                  nx_reg;
    q_t                  ny_reg;
    q_t                  nz_reg;
    q_t                  acc_reg;
    q_t                  mul_res_reg;
    logic [56:0]         tprod_reg;
    logic [3:0]          di_reg;
    logic [1:0]          idx_reg;
    logic [31:0]         sum_reg;
    logic [63:0]         rad_reg;
    logic [32:0]         rem_reg;
    logic [31:0]         root_reg;
    logic [4:0]          cnt_reg;
    logic [3:0]          ei_reg;

    logic                cfg_wr;
    logic [QW:0]         p_init;
    q_t                  mul_a;
    q_t                  mul_b;
    logic                div_start;
    logic [59:0]         div_num;
    logic [31:0]         div_den;
    logic                div_done;
    logic [59:0]         div_quo;
    logic [56:0]         tq;
    q_t                  u_new;
    logic signed [16:0]  comp;
    logic [15:0]         comp_mag;
    logic [31:0]         sum_upd;
    logic [34:0]         sq_rs;
    logic [34:0]         sq_trial;
    logic                sq_ge;
    ent_t                ent;
    q_t                  ni;
    q_t                  nj;
    q_t                  nk;
    q_t                  ed_val;
    q_t                  n_new;

    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_ANGLE:  prdata = {16'b0, angle_reg};
            REG_AXIS_X: prdata = {16'b0, ax_reg};
            REG_AXIS_Y: prdata = {16'b0, ay_reg};
            default:    prdata = {16'b0, az_reg};
        endcase
    end

    aap_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        p_init = {{3{angle_reg[15]}}, angle_reg, 16'b0} + RED_BIAS;
        tq     = tprod_reg >> recip_shift(di_reg);
        u_new  = Q_ONE - q_t'({6'b0, tq[27:0]});

        // The block works with the x component negated.
        case (idx_reg)
            2'd0:    comp = -$signed({ax_reg[15], ax_reg});
            2'd1:    comp = $signed({ay_reg[15], ay_reg});
            default: comp = $signed({az_reg[15], az_reg});
        endcase
        comp_mag = comp[16] ? 16'(-comp) : comp[15:0];
        sum_upd  = sum_reg + comp_mag * comp_mag;
        n_new    = comp[16] ? -q_t'({1'b0, div_quo[QW-2:0]}) : q_t'({1'b0, div_quo[QW-2:0]});

        sq_rs    = {rem_reg, rad_reg[63:62]};
        sq_trial = {1'b0, root_reg, 2'b01};
        sq_ge    = (sq_rs >= sq_trial);

        ent = ent_info(ei_reg);
        case (ent.i)
            2'd0:    ni = nx_reg;
            2'd1:    ni = ny_reg;
            default: ni = nz_reg;
        endcase
        case (ent.j)
            2'd0:    nj = nx_reg;
            2'd1:    nj = ny_reg;
            default: nj = nz_reg;
        endcase
        case (ent.k)
            2'd0:    nk = nx_reg;
            2'd1:    nk = ny_reg;
            default: nk = nz_reg;
        endcase
        if (ent.diag)
            ed_val = acc_reg + cs_reg;
        else if (ent.sub)
            ed_val = acc_reg - mul_res_reg;
        else
            ed_val = acc_reg + mul_res_reg;

        case (state_reg)
            ST_R2:   begin mul_a = r_reg;       mul_b = r_reg;  end
            ST_TM:   begin mul_a = r2_reg;      mul_b = u_reg;  end
            ST_SIN:  begin mul_a = r_reg;       mul_b = u_reg;  end
            ST_EA:   begin mul_a = ni;          mul_b = nj;     end
            ST_EB:   begin mul_a = mul_res_reg; mul_b = t_reg;  end
            ST_EC:   begin mul_a = nk;          mul_b = sn_reg; end
            default: begin mul_a = '0;          mul_b = '0;     end
        endcase

        div_start = (state_reg == ST_NDIV);
        div_num   = {comp_mag, 44'b0} + {29'b0, root_reg[31:1]};
        div_den   = root_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = ST_IDLE;
            ST_START: state_next = ST_RED;
            ST_RED:
            begin
                if (q_reg < HALF_PI)
                    state_next = ST_R2;
            end
            ST_R2:    state_next = ST_R2W;
            ST_R2W:   state_next = ST_TM;
            ST_TM:    state_next = ST_TD;
            ST_TD:    state_next = ST_TW;
            ST_TW:
            begin
                if (di_reg == DI_SIN_LAST)
                    state_next = ST_SIN;
                else if (di_reg == DI_COS_LAST)
                    state_next = ST_QUAD;
                else
                    state_next = ST_TM;
            end
            ST_SIN:   state_next = ST_SINW;
            ST_SINW:  state_next = ST_TM;
            ST_QUAD:  state_next = ST_SUM;
            ST_SUM:
            begin
                if (idx_reg == 2'd2)
                    state_next = (sum_upd == 32'd0) ? ST_IDLE : ST_SQRT;
            end
            ST_SQRT:
            begin
                if (cnt_reg == 5'd0)
                    state_next = ST_NDIV;
            end
            ST_NDIV:  state_next = ST_NW;
            ST_NW:
            begin
                if (div_done)
                    state_next = (idx_reg == 2'd2) ? ST_EA : ST_NDIV;
            end
            ST_EA:    state_next = ST_EB;
            ST_EB:    state_next = ST_EC;
            ST_EC:    state_next = ST_ED;
            ST_ED:    state_next = (ei_reg == EI_LAST) ? ST_IDLE : ST_EA;
            default:  state_next = ST_IDLE;
        endcase
        // A new register value restarts the whole computation.
        if (cfg_wr)
            state_next = ST_START;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            angle_reg <= '0;
            ax_reg    <= '0;
            ay_reg    <= '0;
            az_reg    <= '0;
            zero_reg  <= 1'b1;
            for (int e = 0; e < 9; e++)
                entry_reg[e] <= (e % 4 == 0) ? ENTRY_ONE : '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    REG_ANGLE:  angle_reg <= pwdata[15:0];
                    REG_AXIS_X: ax_reg    <= pwdata[15:0];
                    REG_AXIS_Y: ay_reg    <= pwdata[15:0];
                    REG_AXIS_Z: az_reg    <= pwdata[15:0];
                    default:    angle_reg <= angle_reg;
                endcase
            end
            if (state_reg == ST_SUM && idx_reg == 2'd2 && sum_upd == 32'd0)
            begin
                for (int e = 0; e < 9; e++)
                    entry_reg[e] <= (e % 4 == 0) ? to_entry(cs_reg) : '0;
                zero_reg <= 1'b1;
            end
            if (state_reg == ST_ED)
            begin
                entry_reg[ei_reg] <= to_entry(ed_val);
                if (ei_reg == EI_LAST)
                    zero_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mul_res_reg <= mulq(mul_a, mul_b);
        case (state_reg)
            ST_START:
            begin
                q_reg  <= p_init[QW-1:0];
                kq_reg <= 2'd0;
            end
            ST_RED:
            begin
                if (q_reg >= HALF_PI)
                begin
                    q_reg  <= q_reg - HALF_PI;
                    kq_reg <= kq_reg + 2'd1;
                end
                else
                begin
                    r_reg <= q_t'(q_reg - HALF_PI_HALF);
                end
            end
            ST_R2W:
            begin
                r2_reg <= mul_res_reg;
                u_reg  <= Q_ONE;
                di_reg <= 4'd0;
            end
            ST_TD:
            begin
                tprod_reg <= mul_res_reg[27:0] * recip_mul(di_reg);
            end
            ST_TW:
            begin
                u_reg  <= u_new;
                di_reg <= di_reg + 4'd1;
                if (di_reg == DI_COS_LAST)
                    c_reg <= u_new;
            end
            ST_SINW:
            begin
                s_reg <= mul_res_reg;
                u_reg <= Q_ONE;
            end
            ST_QUAD:
            begin
                case (kq_reg)
                    2'd0:    begin sn_reg <= s_reg;  cs_reg <= c_reg;  end
                    2'd1:    begin sn_reg <= c_reg;  cs_reg <= -s_reg; end
                    2'd2:    begin sn_reg <= -s_reg; cs_reg <= -c_reg; end
                    default: begin sn_reg <= -c_reg; cs_reg <= s_reg;  end
                endcase
                idx_reg <= 2'd0;
                sum_reg <= '0;
            end
            ST_SUM:
            begin
                sum_reg  <= sum_upd;
                idx_reg  <= idx_reg + 2'd1;
                rad_reg  <= {sum_upd, 32'b0};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 5'd31;
            end
            ST_SQRT:
            begin
                rem_reg  <= sq_ge ? 33'(sq_rs - sq_trial) : sq_rs[32:0];
                root_reg <= {root_reg[30:0], sq_ge};
                rad_reg  <= {rad_reg[61:0], 2'b00};
                cnt_reg  <= cnt_reg - 5'd1;
                idx_reg  <= 2'd0;
            end
            ST_NW:
            begin
                if (div_done)
                begin
                    case (idx_reg)
                        2'd0:    nx_reg <= n_new;
                        2'd1:    ny_reg <= n_new;
                        default: nz_reg <= n_new;
                    endcase
                    idx_reg <= idx_reg + 2'd1;
                    t_reg   <= Q_ONE - cs_reg;
                    ei_reg  <= 4'd0;
                end
            end
            ST_EC:   acc_reg <= mul_res_reg;
            ST_ED:   ei_reg  <= ei_reg + 4'd1;
            default: q_reg   <= q_reg;
        endcase
    end

    always_comb
    begin
        coef.busy      = (state_reg != ST_IDLE);
        coef.zero_axis = zero_reg;
        for (int e = 0; e < 9; e++)
            coef.entry[e] = entry_reg[e];
    end

endmodule

// ----- hdl/aap_fifo.sv -----
`timescale 1ns / 1ps

module aap_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  aap_pkg::point_t wdata,
    input  logic            pop,
    output aap_pkg::point_t rdata,
    output logic            empty,
    output logic            full
);
    import aap_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    point_t        mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ----- hdl/aap_back.sv -----
`timescale 1ns / 1ps

module aap_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pt_valid,
    input  aap_pkg::point_t pt,
    output logic            pop,
    input  aap_pkg::coef_t  coef,
    aap_result_if.source    res
);
    import aap_pkg::*;

    localparam int PROD_W = ENTRY_W + COORD_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W - 16;

    function automatic coord_t round_sat(logic signed [SUM_W-1:0] acc);
        logic [SUM_W-1:0] mg;
        logic [RND_W-1:0] rm;
        mg = acc[SUM_W-1] ? -acc : acc;
        rm = RND_W'((mg + SUM_W'(32768)) >> 16);
        if (!acc[SUM_W-1] && rm > RND_W'(32'h7FFFFFFF))
            return 32'sh7FFFFFFF;
        else if (acc[SUM_W-1] && rm > RND_W'(33'h080000000))
            return 32'sh80000000;
        else
            return acc[SUM_W-1] ? coord_t'(-rm) : coord_t'(rm);
    endfunction

    logic                      en;
    logic                      s1_valid_reg;
    logic                      s1_zero_reg;
    logic signed [PROD_W-1:0]  prod_reg [9];
    logic                      out_valid_reg;
    logic                      out_zero_reg;
    coord_t                    rot_reg [3];
    coord_t                    pc [3];
    logic signed [SUM_W-1:0]   row_sum [3];

    // The pipeline moves whenever the output slot is free or being emptied.
    assign en  = !out_valid_reg || res.ready;
    assign pop = en && pt_valid;

    always_comb
    begin
        pc[0] = pt.x;
        pc[1] = pt.y;
        pc[2] = pt.z;
        for (int i = 0; i < 3; i++)
            row_sum[i] = SUM_W'(prod_reg[3*i]) + SUM_W'(prod_reg[3*i+1])
                       + SUM_W'(prod_reg[3*i+2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= pt_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < 9; e++)
                prod_reg[e] <= PROD_W'($signed(coef.entry[e]) * pc[e % 3]);
            s1_zero_reg  <= coef.zero_axis;
            for (int i = 0; i < 3; i++)
                rot_reg[i] <= round_sat(row_sum[i]);
            out_zero_reg <= s1_zero_reg;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.rotated_x = rot_reg[0];
    assign res.rotated_y = rot_reg[1];
    assign res.rotated_z = rot_reg[2];
    assign res.zero_axis = out_zero_reg;

endmodule

// ----- hdl/axis_angle_point_rotation_core.sv -----
`timescale 1ns / 1ps

// Rotates a stream of Q16.16 points about an axis by an angle.
// Software writes the angle and the axis components over the APB port; every
// write restarts the matrix computation (sine and cosine series on one shared
// multiplier, with the series divisions done as reciprocal multiplies, then a
// serial square root and serial normalizing divides). The run time is set
// mostly by the divider, run three times for the axis, and by the 32-step
// square root.
// While it runs, points.ready stays low; the matrix is the identity after
// reset, and the zero_axis flag reads 1 until a nonzero axis is written.
// Points enter a small queue and are then multiplied by the matrix in two
// pipeline stages, one transaction per cycle in steady state. A point passes through
// the queue, the product registers and the output register. When the receiver
// stalls, the output register holds its transaction, the pipeline freezes and
// the queue keeps taking points until it is full.
module axis_angle_point_rotation_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    aap_point_if.sink   points,
    aap_result_if.source rotated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import aap_pkg::*;

    coef_t  coef;
    point_t in_pt;
    point_t q_pt;
    logic   push;
    logic   pop;
    logic   q_empty;
    logic   q_full;
    logic   cfg_wr;

    assign pready        = 1'b1;
    assign cfg_wr        = psel & penable & pwrite;
    assign points.ready  = !q_full && !coef.busy && !cfg_wr;
    assign push          = points.valid && points.ready;
    assign in_pt.x       = points.point_x;
    assign in_pt.y       = points.point_y;
    assign in_pt.z       = points.point_z;

    aap_mat u_mat (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .coef    (coef)
    );

    aap_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_pt),
        .pop   (pop),
        .rdata (q_pt),
        .empty (q_empty),
        .full  (q_full)
    );

    aap_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pt_valid (!q_empty),
        .pt       (q_pt),
        .pop      (pop),
        .coef     (coef),
        .res      (rotated)
    );

endmodule

// ----- bench/axis_angle_point_rotation_core_tb.sv -----
`timescale 1ns / 1ps

module axis_angle_point_rotation_core_tb;
    import aap_pkg::*;

    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  HOLD_CYCLES = 300;
    localparam longint ONE_Q28  = 64'sd268435456;
    localparam longint QTR_TURN = 64'sd421657428;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   zero_axis;
    } rotated_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    aap_point_if  points ();
    aap_result_if rotated ();

    axis_angle_point_rotation_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (points.sink),
        .rotated (rotated.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: shadow registers and the matrix they imply.
    logic signed [15:0] shadow_reg [4];
    longint             rot_entry [9];
    logic               rot_zero_axis;

    point_t   pending_points [$];
    rotated_t expected_points [$];
    int       fail_count;
    int       cycle_count;
    int       stall_mode;
    int       hold_requests;
    int       holds_done;
    int       hold_left;
    int       burst_left;
    int       gap_left;

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint mul_q28(longint a, longint b);
        longint p;
        p = (mag(a) * mag(b) + (64'sd1 <<< 27)) >>> 28;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic longint round_off(longint v, int sh);
        longint m;
        m = (mag(v) + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint saturate(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint q28_to_entry(longint v);
        return saturate(round_off(v, 12), -131072, 131071);
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] res;
        bit [63:0] bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v)
            bt >>= 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic void sine_cosine(input longint ang, output longint sn, output longint cs);
        longint sdiv [5] = '{110, 72, 42, 20, 6};
        longint cdiv [6] = '{132, 90, 56, 30, 12, 2};
        longint a, k, r, r2, u, s, c;
        a = ang * 65536;
        k = (a + 8 * QTR_TURN + QTR_TURN / 2) / QTR_TURN - 8;
        r = a - k * QTR_TURN;
        r2 = mul_q28(r, r);
        u = ONE_Q28;
        for (int i = 0; i < 5; i++)
            u = ONE_Q28 - mul_q28(r2, u) / sdiv[i];
        s = mul_q28(r, u);
        u = ONE_Q28;
        for (int i = 0; i < 6; i++)
            u = ONE_Q28 - mul_q28(r2, u) / cdiv[i];
        c = u;
        case (k & 3)
            0: begin sn = s;  cs = c;  end
            1: begin sn = c;  cs = -s; end
            2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    function automatic void rebuild_matrix();
        longint    ax [3];
        longint    nv [3];
        longint    e [9];
        longint    s, c, t;
        bit [63:0] sum, m;
        ax[0] = -longint'(shadow_reg[REG_AXIS_X]);
        ax[1] = longint'(shadow_reg[REG_AXIS_Y]);
        ax[2] = longint'(shadow_reg[REG_AXIS_Z]);
        sine_cosine(longint'(shadow_reg[REG_ANGLE]), s, c);
        sum = 0;
        for (int i = 0; i < 3; i++)
            sum += mag(ax[i]) * mag(ax[i]);
        if (sum == 0)
        begin
            for (int i = 0; i < 9; i++)
                rot_entry[i] = (i % 4 == 0) ? q28_to_entry(c) : 0;
            rot_zero_axis = 1'b1;
            return;
        end
        m = int_sqrt(sum << 32);
        for (int i = 0; i < 3; i++)
        begin
            nv[i] = longint'(((64'(mag(ax[i])) << 44) + m / 2) / m);
            if (ax[i] < 0)
                nv[i] = -nv[i];
        end
        t = ONE_Q28 - c;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                e[i*3+j] = mul_q28(mul_q28(nv[i], nv[j]), t);
        e[0] += c;
        e[4] += c;
        e[8] += c;
        e[1] -= mul_q28(nv[2], s);
        e[2] += mul_q28(nv[1], s);
        e[3] += mul_q28(nv[2], s);
        e[5] -= mul_q28(nv[0], s);
        e[6] -= mul_q28(nv[1], s);
        e[7] += mul_q28(nv[0], s);
        for (int i = 0; i < 9; i++)
            rot_entry[i] = q28_to_entry(e[i]);
        rot_zero_axis = 1'b0;
    endfunction

    function automatic rotated_t rotate_point(point_t p);
        longint   pv [3];
        longint   acc;
        coord_t   outv [3];
        rotated_t r;
        pv[0] = longint'(p.x);
        pv[1] = longint'(p.y);
        pv[2] = longint'(p.z);
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += rot_entry[i*3+j] * pv[j];
            outv[i] = coord_t'(saturate(round_off(acc, 16), -64'sd2147483648, 64'sd2147483647));
        end
        r.x = outv[0];
        r.y = outv[1];
        r.z = outv[2];
        r.zero_axis = rot_zero_axis;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        points.valid = 1'b0;
        points.point_x = '0;
        points.point_y = '0;
        points.point_z = '0;
        rotated.ready = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        point_t sent;
        if (rst_n)
        begin
            if (points.valid && points.ready)
            begin
                sent = pending_points.pop_front();
                expected_points = {expected_points, rotate_point(sent)};
            end
            if (!points.valid || points.ready)
            begin
                if (gap_left > 0)
                begin
                    points.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_points.size() > 0)
                begin
                    points.valid <= 1'b1;
                    points.point_x <= pending_points[0].x;
                    points.point_y <= pending_points[0].y;
                    points.point_z <= pending_points[0].z;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    points.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern per phase, plus long hold-offs on request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                rotated.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_requests != holds_done)
            begin
                rotated.ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                holds_done <= holds_done + 1;
            end
            else
            begin
                case (stall_mode)
                    0: rotated.ready <= 1'b1;
                    1: rotated.ready <= $urandom_range(0, 1);
                    default: rotated.ready <= (cycle_count % 7) >= 2;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        rotated_t want;
        if (rst_n && rotated.valid && rotated.ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected result transaction x=%0d y=%0d z=%0d",
                       rotated.rotated_x, rotated.rotated_y, rotated.rotated_z);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = expected_points.pop_front();
                if (rotated.rotated_x !== want.x)
                begin
                    $error("rotated_x expected %0d got %0d", want.x, rotated.rotated_x);
                    fail_count = fail_count + 1;
                end
                if (rotated.rotated_y !== want.y)
                begin
                    $error("rotated_y expected %0d got %0d", want.y, rotated.rotated_y);
                    fail_count = fail_count + 1;
                end
                if (rotated.rotated_z !== want.z)
                begin
                    $error("rotated_z expected %0d got %0d", want.z, rotated.rotated_z);
                    fail_count = fail_count + 1;
                end
                if (rotated.zero_axis !== want.zero_axis)
                begin
                    $error("zero_axis expected %0d got %0d", want.zero_axis, rotated.zero_axis);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic signed [15:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {{16{val[15]}}, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_reg[idx] = val;
        rebuild_matrix();
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || expected_points.size() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    function automatic coord_t random_coord();
        case ($urandom_range(0, 9)) inside
            [0:3]: return coord_t'($urandom);
            [4:7]: return coord_t'($signed($urandom_range(0, 2097152)) - 1048576);
            8: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return coord_t'($signed($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    task automatic queue_point(coord_t x, coord_t y, coord_t z);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        pending_points = {pending_points, p};
    endtask

    task automatic config_all(logic signed [15:0] ang, logic signed [15:0] ax,
                              logic signed [15:0] ay, logic signed [15:0] az);
        write_reg(REG_ANGLE, ang);
        write_reg(REG_AXIS_X, ax);
        write_reg(REG_AXIS_Y, ay);
        write_reg(REG_AXIS_Z, az);
    endtask

    initial
    begin
        int n_items;
        fail_count = 0;
        cycle_count = 0;
        stall_mode = 0;
        hold_requests = 0;
        holds_done = 0;
        hold_left = 0;
        burst_left = 1;
        gap_left = 0;
        for (int i = 0; i < 4; i++)
            shadow_reg[i] = '0;
        rebuild_matrix();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Before any configuration the identity matrix applies.
        queue_point(32'sh7fffffff, 32'sh80000000, 32'sd0);
        queue_point(32'sd1, -32'sd1, 32'sh00010000);
        queue_point(32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff);
        drain();

        // A quarter turn about z, extreme angles, and a zero axis with an angle.
        config_all(16'sd6434, 16'sd0, 16'sd0, 16'sd4096);
        queue_point(32'sh00010000, 32'sd0, 32'sd0);
        queue_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        drain();
        config_all(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
        queue_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
        queue_point(32'sh12345678, -32'sd7, 32'sh7fffffff);
        drain();
        config_all(16'sh8000, 16'sh7fff, 16'sd1, -16'sd1);
        queue_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        queue_point(32'sd3, 32'sd5, -32'sd9);
        drain();
        config_all(16'sd12868, 16'sd0, 16'sd0, 16'sd0);
        queue_point(32'sh00030000, -32'sh00020000, 32'sh7fffffff);
        queue_point(32'sh80000000, 32'sd1, 32'sd0);
        drain();
        config_all(16'sd0, 16'sd1, 16'sd0, 16'sd0);
        queue_point(32'sh00008000, -32'sh00008000, 32'sh00018000);
        drain();

        for (int ph = 0; ph < 30; ph++)
        begin
            stall_mode = $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0)
                config_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
            begin
                for (int r = 0; r < 4; r++)
                    if ($urandom_range(0, 1))
                        write_reg(r[1:0], ($urandom_range(0, 4) == 0) ?
                                  16'(4096 * $signed($urandom_range(0, 2)) - 4096) :
                                  16'($urandom));
            end
            if (ph % 10 == 3)
                hold_requests = hold_requests + 1;
            n_items = $urandom_range(35, 65);
            for (int i = 0; i < n_items; i++)
                queue_point(random_coord(), random_coord(), random_coord());
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
